@@ rtl/core/dst_correction_decider_defines.svh @@
// Assertion macros for the daylight-saving correction decider.
`ifndef DST_CORRECTION_DECIDER_DEFINES_SVH
`define DST_CORRECTION_DECIDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define DCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dcd assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define DCD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dcd assertion failed");

`endif

@@ rtl/core/dcd_pkg.sv @@
// Package: codes, widths, window tables and shared types of the decider.
package dcd_pkg;

	localparam int MODE_W  = 2;
	localparam int YEAR_W  = 7;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int CHG_W   = 2;
	localparam int REGION_W = 2;
	localparam int NYEARS  = 7;
	localparam int IDX_W   = 3;

	localparam logic [MODE_W-1:0] MODE_FIX    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GPS    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [REGION_W-1:0] REGION_NONE = 2'd0;
	localparam logic [REGION_W-1:0] REGION_US   = 2'd1;
	localparam logic [REGION_W-1:0] REGION_EU   = 2'd2;

	localparam logic [CHG_W-1:0] CHG_NONE    = 2'd0;
	localparam logic [CHG_W-1:0] CHG_ADVANCE = 2'd1;
	localparam logic [CHG_W-1:0] CHG_RETREAT = 2'd2;
	localparam logic [CHG_W-1:0] CHG_BOTH    = 2'd3;

	localparam logic [YEAR_W-1:0]  FIRST_YEAR      = 7'd8;
	localparam logic [YEAR_W-1:0]  LAST_YEAR       = 7'd14;
	localparam logic [DAY_W-1:0]   EU_DAY_BASE     = 5'd25;
	localparam logic [MONTH_W-1:0] FORWARD_MONTH   = 4'd3;
	localparam logic [MONTH_W-1:0] US_BACK_MONTH   = 4'd11;
	localparam logic [MONTH_W-1:0] EU_BACK_MONTH   = 4'd10;
	localparam logic [HOUR_W-1:0]  US_FORWARD_HOUR = 5'd2;
	localparam logic [HOUR_W-1:0]  EU_FORWARD_HOUR = 5'd1;
	localparam logic [HOUR_W-1:0]  BACK_HOUR       = 5'd2;
	localparam logic [HOUR_W-1:0]  LAST_HOUR       = 5'd1;

	// Forward day in the high nibble, back day in the low nibble.
	localparam logic [7:0] US_DAYS [8] = '{
		8'h92, 8'h81, 8'hE7, 8'hD6, 8'hB4, 8'hA3, 8'h92, 8'h00
	};
	// EU days are offsets from the 25th.
	localparam logic [7:0] EU_DAYS [8] = '{
		8'h51, 8'h40, 8'h36, 8'h25, 8'h03, 8'h62, 8'h51, 8'h00
	};

	typedef struct packed {
		logic             supported;
		logic [IDX_W-1:0] idx;
		logic             inwin;
		logic             last_hr;
		logic             post;
	} win_flags_t;

endpackage

@@ rtl/core/dcd_if.sv @@
// Valid/ready channel interfaces for the decider's date items and results.
interface dcd_in_if;
	import dcd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [YEAR_W-1:0]    year;
	logic [MONTH_W-1:0]   month;
	logic [DAY_W-1:0]     day;
	logic [HOUR_W-1:0]    hour;
	modport source (output valid, mode, year, month, day, hour, input ready);
	modport sink (input valid, mode, year, month, day, hour, output ready);
endinterface

interface dcd_out_if;
	import dcd_pkg::*;
	logic             valid;
	logic             ready;
	logic [CHG_W-1:0] hour_change;
	logic             in_window;
	logic             forward_marked;
	logic             backward_marked;
	modport source (output valid, hour_change, in_window, forward_marked, backward_marked,
		input ready);
	modport sink (input valid, hour_change, in_window, forward_marked, backward_marked,
		output ready);
endinterface

@@ rtl/core/dcd_window.sv @@
// Window lookup: year support, table index and position against the window.
module dcd_window
	import dcd_pkg::*;
(
	input  logic [REGION_W-1:0] region,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	input  logic [HOUR_W-1:0]   hour,
	output win_flags_t          flags
);

	logic [YEAR_W-1:0]  year_off;
	logic [IDX_W-1:0]   idx;
	logic [7:0]         us_e;
	logic [7:0]         eu_e;
	logic [DAY_W-1:0]   fday;
	logic [DAY_W-1:0]   bday;
	logic [HOUR_W-1:0]  fhr;
	logic [MONTH_W-1:0] bmon;
	logic               is_us;
	logic               inwin;

	assign year_off = year - FIRST_YEAR;
	assign idx      = year_off[IDX_W-1:0];
	assign us_e     = US_DAYS[idx];
	assign eu_e     = EU_DAYS[idx];
	assign is_us    = (region == REGION_US);

	always_comb begin
		if (is_us) begin
			fday = {1'b0, us_e[7:4]};
			bday = {1'b0, us_e[3:0]};
			fhr  = US_FORWARD_HOUR;
			bmon = US_BACK_MONTH;
		end else begin
			fday = {1'b0, eu_e[7:4]} + EU_DAY_BASE;
			bday = {1'b0, eu_e[3:0]} + EU_DAY_BASE;
			fhr  = EU_FORWARD_HOUR;
			bmon = EU_BACK_MONTH;
		end
	end

	// Walk the month first, then the day, then the hour at each boundary.
	always_comb begin
		if (month < FORWARD_MONTH) begin
			inwin = 1'b0;
		end else if (month == FORWARD_MONTH) begin
			inwin = (day > fday) || (day == fday && hour >= fhr);
		end else if (month < bmon) begin
			inwin = 1'b1;
		end else if (month > bmon) begin
			inwin = 1'b0;
		end else if (day < bday) begin
			inwin = 1'b1;
		end else if (day > bday) begin
			inwin = 1'b0;
		end else begin
			inwin = hour < BACK_HOUR;
		end
	end

	assign flags.supported = (region == REGION_US || region == REGION_EU) &&
		(year >= FIRST_YEAR) && (year <= LAST_YEAR);
	assign flags.idx     = idx;
	assign flags.inwin   = inwin;
	assign flags.last_hr = inwin && month == bmon && day == bday && hour == LAST_HOUR;
	assign flags.post    = (month > bmon) || (month == bmon && day > bday) ||
		(month == bmon && day == bday && hour >= BACK_HOUR);

endmodule

@@ rtl/core/dst_correction_decider.sv @@
// Top level: daylight-saving correction decider with per-year applied marks.
// An accepted item waits in the input stage, its result in the result stage.
// Throughput: one item per cycle unless the result side stalls; the only loop is
// the per-year mark pair, read and updated in the single decision stage.
// Reset: arst_n clears the region register (no daylight saving), both mark
// registers and all valid flags; payload registers are not reset.
module dst_correction_decider
	import dcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                region_we,
	input  logic [REGION_W-1:0] region_wdata,
	dcd_in_if.sink              item,
	dcd_out_if.source           result
);

	`include "dst_correction_decider_defines.svh"

	// Region register, written only while the block is idle: a user rule, unchecked.
	logic [REGION_W-1:0] region_q;

	// Input stage: the accepted beat waits here for the decision.
	logic               valid_s1;
	logic [MODE_W-1:0]  mode_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [HOUR_W-1:0]  hour_s1;

	// Result stage.
	logic             valid_s2;
	logic [CHG_W-1:0] change_s2;
	logic             win_s2;
	logic             fmark_s2;
	logic             bmark_s2;

	// Per-year marks: bit (year - 8).
	logic [NYEARS-1:0] fwd_done_q;
	logic [NYEARS-1:0] bwd_done_q;

	win_flags_t        flags;
	logic              advance;
	logic              ok;
	logic [NYEARS-1:0] year_bit;
	logic              fdone;
	logic              bdone;
	logic [CHG_W-1:0]  change_d;
	logic              win_d;
	logic              fmark_d;
	logic              bmark_d;

	// Move the decided beat forward when the result stage is empty or draining.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_NONE;
		end else if (region_we) begin
			region_q <= region_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1  <= item.mode;
			year_s1  <= item.year;
			month_s1 <= item.month;
			day_s1   <= item.day;
			hour_s1  <= item.hour;
		end
	end

	dcd_window u_window (
		.region (region_q),
		.year   (year_s1),
		.month  (month_s1),
		.day    (day_s1),
		.hour   (hour_s1),
		.flags  (flags)
	);

	// One-hot select of this year's mark bit.
	always_comb begin
		for (int i = 0; i < NYEARS; i++) begin
			year_bit[i] = (flags.idx == IDX_W'(i));
		end
	end

	assign ok    = flags.supported && (mode_s1 != MODE_UNUSED);
	assign fdone = |(fwd_done_q & year_bit);
	assign bdone = |(bwd_done_q & year_bit);

	// Decision. Unsupported year, region or mode: all-zero result, marks hold.
	always_comb begin
		change_d = CHG_NONE;
		win_d    = 1'b0;
		fmark_d  = 1'b0;
		bmark_d  = 1'b0;
		if (ok) begin
			if (mode_s1 == MODE_GPS) begin
				// Query only: report the window, close the year in its last hour.
				win_d   = flags.inwin && !flags.last_hr;
				bmark_d = flags.last_hr && !bdone;
			end else if (flags.inwin) begin
				if (!fdone) begin
					fmark_d = 1'b1;
					if (mode_s1 == MODE_FIX) begin
						change_d = CHG_ADVANCE;
						// Advancing from the last hour steps past the switch.
						if (flags.last_hr && !bdone) begin
							change_d = CHG_BOTH;
							bmark_d  = 1'b1;
						end
					end
				end
			end else if (flags.post && fdone && !bdone && mode_s1 == MODE_FIX) begin
				change_d = CHG_RETREAT;
				bmark_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_done_q <= '0;
			bwd_done_q <= '0;
		end else if (advance) begin
			if (fmark_d) begin
				fwd_done_q <= fwd_done_q | year_bit;
			end
			if (bmark_d) begin
				bwd_done_q <= bwd_done_q | year_bit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			change_s2 <= change_d;
			win_s2    <= win_d;
			fmark_s2  <= fmark_d;
			bmark_s2  <= bmark_d;
		end
	end

	assign result.valid           = valid_s2;
	assign result.hour_change     = change_s2;
	assign result.in_window       = win_s2;
	assign result.forward_marked  = fmark_s2;
	assign result.backward_marked = bmark_s2;

	// Advance-then-retreat always sets both marks.
	`DCD_ASSERT_IMP(a_both_marks, valid_s2 && change_s2 == CHG_BOTH, fmark_s2 && bmark_s2)
	// A window answer never comes with a clock change or a forward mark.
	`DCD_ASSERT_IMP(a_gps_quiet, valid_s2 && win_s2, change_s2 == CHG_NONE && !fmark_s2)
	// Marks only accumulate.
	`DCD_ASSERT_NXT(a_marks_grow, 1'b1,
		((fwd_done_q & $past(fwd_done_q)) == $past(fwd_done_q)) &&
		((bwd_done_q & $past(bwd_done_q)) == $past(bwd_done_q)))

endmodule

@@ tb/tb_dst_correction_decider.sv @@
// Self-checking testbench for the daylight-saving correction decider.
module tb_dst_correction_decider;
	import dcd_pkg::*;

	// Region code the package leaves unnamed.
	localparam logic [REGION_W-1:0] REGION_RESERVED = 2'd3;

	// Cycles to let pass once nothing is expected: the path through the
	// input and result stages plus margin, to catch a stray beat.
	localparam int SETTLE_CYCLES = 8;
	// Hard stop, far above the slowest correct run.
	localparam int RUN_LIMIT     = 2_000_000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
	} date_item_t;

	typedef struct packed {
		logic [CHG_W-1:0] hour_change;
		logic             in_window;
		logic             forward_marked;
		logic             backward_marked;
	} decision_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                region_we;
	logic [REGION_W-1:0] region_wdata;

	dcd_in_if  item_bus ();
	dcd_out_if result_bus ();

	dst_correction_decider u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.region_we    (region_we),
		.region_wdata (region_wdata),
		.item         (item_bus),
		.result       (result_bus)
	);

	// Predictor state: region register and the per-year applied marks.
	logic [REGION_W-1:0] region_model;
	logic [NYEARS-1:0]   forward_applied;
	logic [NYEARS-1:0]   backward_applied;

	date_item_t dates_to_send [$];
	decision_t  decisions_due [$];
	int         mismatch_count;
	int         src_idle_pct;
	int         snk_stall_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out what the block must answer for one date, and advance the marks.
	function automatic decision_t decide_correction(date_item_t d);
		decision_t          v;
		logic [IDX_W-1:0]   slot;
		logic [DAY_W-1:0]   fwd_day;
		logic [DAY_W-1:0]   back_day;
		logic [7:0]         days;
		logic [HOUR_W-1:0]  fwd_hour;
		logic [MONTH_W-1:0] back_month;
		logic               inwin;
		logic               last_hr;
		logic               post;
		logic               fdone;
		logic               bdone;
		v = '0;
		if ((region_model != REGION_US && region_model != REGION_EU) ||
			d.mode == MODE_UNUSED || d.year < FIRST_YEAR || d.year > LAST_YEAR)
			return v;
		slot = IDX_W'(d.year - FIRST_YEAR);
		if (region_model == REGION_US) begin
			days       = US_DAYS[slot];
			fwd_day    = {1'b0, days[7:4]};
			back_day   = {1'b0, days[3:0]};
			fwd_hour   = US_FORWARD_HOUR;
			back_month = US_BACK_MONTH;
		end else begin
			days       = EU_DAYS[slot];
			fwd_day    = {1'b0, days[7:4]} + EU_DAY_BASE;
			back_day   = {1'b0, days[3:0]} + EU_DAY_BASE;
			fwd_hour   = EU_FORWARD_HOUR;
			back_month = EU_BACK_MONTH;
		end
		// Out-of-calendar values compare as plain numbers.
		if (d.month < FORWARD_MONTH)
			inwin = 1'b0;
		else if (d.month == FORWARD_MONTH)
			inwin = (d.day > fwd_day) || (d.day == fwd_day && d.hour >= fwd_hour);
		else if (d.month < back_month)
			inwin = 1'b1;
		else if (d.month > back_month)
			inwin = 1'b0;
		else if (d.day < back_day)
			inwin = 1'b1;
		else if (d.day > back_day)
			inwin = 1'b0;
		else
			inwin = d.hour < BACK_HOUR;
		last_hr = inwin && d.month == back_month && d.day == back_day &&
			d.hour == LAST_HOUR;
		post = (d.month > back_month) || (d.month == back_month && d.day > back_day) ||
			(d.month == back_month && d.day == back_day && d.hour >= BACK_HOUR);
		fdone = forward_applied[slot];
		bdone = backward_applied[slot];
		if (d.mode == MODE_GPS) begin
			v.in_window = inwin && !last_hr;
			if (last_hr && !bdone) begin
				backward_applied[slot] = 1'b1;
				v.backward_marked      = 1'b1;
			end
		end else if (inwin) begin
			if (!fdone) begin
				forward_applied[slot] = 1'b1;
				v.forward_marked      = 1'b1;
				if (d.mode == MODE_FIX) begin
					v.hour_change = CHG_ADVANCE;
					// Advance out of the last hour leaves the window again.
					if (last_hr && !bdone) begin
						v.hour_change          = CHG_BOTH;
						backward_applied[slot] = 1'b1;
						v.backward_marked      = 1'b1;
					end
				end
			end
		end else if (post && fdone && !bdone && d.mode == MODE_FIX) begin
			v.hour_change          = CHG_RETREAT;
			backward_applied[slot] = 1'b1;
			v.backward_marked      = 1'b1;
		end
		return v;
	endfunction

	// Mostly dates of a supported year, half on its window edges; the
	// rest is noise over the full width of every field.
	function automatic date_item_t shape_date();
		date_item_t d;
		logic [7:0] days;
		int         delta;
		int         fwd_day;
		int         back_day;
		if ($urandom_range(99, 0) < 20) begin
			d.mode  = MODE_W'($urandom_range(3, 0));
			d.year  = YEAR_W'($urandom_range(127, 0));
			d.month = MONTH_W'($urandom_range(15, 0));
			d.day   = DAY_W'($urandom_range(31, 0));
			d.hour  = HOUR_W'($urandom_range(31, 0));
			return d;
		end
		d.mode = ($urandom_range(19, 0) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(2, 0));
		d.year = YEAR_W'(FIRST_YEAR + $urandom_range(NYEARS - 1, 0));
		if (region_model == REGION_EU) begin
			days     = EU_DAYS[d.year - FIRST_YEAR];
			fwd_day  = int'(days[7:4]) + int'(EU_DAY_BASE);
			back_day = int'(days[3:0]) + int'(EU_DAY_BASE);
		end else begin
			days     = US_DAYS[d.year - FIRST_YEAR];
			fwd_day  = int'(days[7:4]);
			back_day = int'(days[3:0]);
		end
		delta = int'($urandom_range(2, 0)) - 1;
		case ($urandom_range(3, 0))
			0: begin
				d.month = FORWARD_MONTH;
				d.day   = DAY_W'(fwd_day + delta);
			end
			1: begin
				d.month = (region_model == REGION_EU) ? EU_BACK_MONTH : US_BACK_MONTH;
				d.day   = DAY_W'(back_day + delta);
			end
			default: begin
				d.month = MONTH_W'($urandom_range(12, 1));
				d.day   = DAY_W'($urandom_range(31, 1));
			end
		endcase
		// Hours around the switch points get half the weight.
		d.hour = HOUR_W'($urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom_range(23, 0));
		return d;
	endfunction

	function automatic void note_mismatch(string what, decision_t want, decision_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected chg=%0d win=%0b fwd=%0b back=%0b",
				$time, what, want.hour_change, want.in_window, want.forward_marked,
				want.backward_marked);
			$display("    got chg=%0d win=%0b fwd=%0b back=%0b",
				got.hour_change, got.in_window, got.forward_marked, got.backward_marked);
		end
	endfunction

	// Driver: present the next queued date once the previous beat has gone.
	always @(posedge clk or negedge arst_n) begin
		date_item_t d;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.mode  <= '0;
			item_bus.year  <= '0;
			item_bus.month <= '0;
			item_bus.day   <= '0;
			item_bus.hour  <= '0;
		end else if (!item_bus.valid || item_bus.ready) begin
			if (dates_to_send.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
				d = dates_to_send.pop_front();
				item_bus.valid <= 1'b1;
				item_bus.mode  <= d.mode;
				item_bus.year  <= d.year;
				item_bus.month <= d.month;
				item_bus.day   <= d.day;
				item_bus.hour  <= d.hour;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// Result side backpressure: stall at the phase's rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_bus.ready <= 1'b0;
		else
			result_bus.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
	end

	// Input monitor: predict every accepted date beat in order.
	always @(posedge clk) begin
		if (arst_n && item_bus.valid && item_bus.ready)
			decisions_due.push_back(decide_correction('{item_bus.mode, item_bus.year,
				item_bus.month, item_bus.day, item_bus.hour}));
	end

	// Output monitor: check each result beat against the oldest prediction.
	always @(posedge clk) begin
		decision_t got;
		decision_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = '{result_bus.hour_change, result_bus.in_window,
				result_bus.forward_marked, result_bus.backward_marked};
			if (decisions_due.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = decisions_due.pop_front();
				if (got !== want)
					note_mismatch("decision mismatch", want, got);
			end
		end
	end

	// Hold until every queued date has been sent and answered, then drain.
	task automatic settle();
		while (dates_to_send.size() != 0 || item_bus.valid || decisions_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the region register while the block is idle; mirror it in the predictor.
	task automatic set_region(input logic [REGION_W-1:0] r, input int src_pct,
		input int snk_pct);
		region_we    <= 1'b1;
		region_wdata <= r;
		@(posedge clk);
		region_we     <= 1'b0;
		region_model  = r;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic queue_date(input logic [MODE_W-1:0] mode, input int year, input int month,
		input int day, input int hour);
		dates_to_send.push_back('{mode, YEAR_W'(year), MONTH_W'(month), DAY_W'(day),
			HOUR_W'(hour)});
	endtask

	task automatic random_phase(input logic [REGION_W-1:0] r, input int count,
		input int src_pct, input int snk_pct);
		settle();
		set_region(r, src_pct, snk_pct);
		repeat (count) dates_to_send.push_back(shape_date());
	endtask

	initial begin
		// Hold the configuration port idle and clear the predictor from time zero.
		arst_n           = 1'b0;
		region_we        = 1'b0;
		region_wdata     = REGION_NONE;
		region_model     = REGION_NONE;
		forward_applied  = '0;
		backward_applied = '0;
		mismatch_count   = 0;
		src_idle_pct     = 0;
		snk_stall_pct    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed, US rules. Each year gets a fresh pair of marks, so order
		// matters: walk the mark transitions before random traffic sets them all.
		set_region(REGION_US, 0, 0);
		queue_date(MODE_FIX, 8, 1, 1, 0);      // before the window
		queue_date(MODE_FIX, 8, 3, 9, 1);      // forward day, one hour early
		queue_date(MODE_FIX, 8, 3, 9, 2);      // window opens: advance
		queue_date(MODE_FIX, 8, 12, 31, 23);   // after the window: retreat
		queue_date(MODE_FIX, 9, 11, 1, 1);     // last hour: advance then retreat
		queue_date(MODE_MARK, 10, 6, 15, 12);  // mark only, no shift
		queue_date(MODE_MARK, 10, 11, 8, 0);   // mark-only mode ignores the retreat
		queue_date(MODE_FIX, 10, 11, 7, 2);    // back day at the switch: retreat
		queue_date(MODE_GPS, 11, 7, 4, 10);    // query inside the window
		queue_date(MODE_GPS, 11, 11, 6, 1);    // query in the last hour sets back mark
		queue_date(MODE_GPS, 11, 11, 6, 1);    // mark already set
		queue_date(MODE_FIX, 11, 11, 6, 1);    // last hour with back mark set: advance only
		queue_date(MODE_UNUSED, 12, 6, 1, 0);  // mode with no meaning
		queue_date(MODE_FIX, 7, 6, 1, 0);      // year below the table
		queue_date(MODE_FIX, 15, 6, 1, 0);     // year above the table
		queue_date(MODE_FIX, 127, 15, 31, 31); // every field at its top
		queue_date(MODE_GPS, 12, 0, 0, 0);     // zero month and day

		// Directed, EU rules: one hour earlier forward, October back day.
		settle();
		set_region(REGION_EU, 0, 0);
		queue_date(MODE_FIX, 13, 3, 31, 0);    // forward day before 01:00
		queue_date(MODE_FIX, 13, 3, 31, 1);    // window opens at 01:00
		queue_date(MODE_FIX, 14, 10, 26, 1);   // last hour: advance then retreat
		queue_date(MODE_GPS, 12, 10, 28, 2);   // at the switch: outside
		queue_date(MODE_FIX, 12, 15, 31, 31);  // month past the calendar, no forward mark
		queue_date(MODE_FIX, 12, 10, 27, 23);  // day before back day: advance

		// Random phases over every region code and idling pattern.
		random_phase(REGION_US,       250,  0,  0);
		random_phase(REGION_EU,       250, 71,  0);
		random_phase(REGION_US,       200,  0, 71);
		random_phase(REGION_EU,       250, 15, 15);
		random_phase(REGION_NONE,     100,  0, 71);
		random_phase(REGION_RESERVED, 100, 71,  0);

		// Let the result side run free so a stray beat shows up during the drain.
		settle();
		snk_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(RUN_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
